// File: rtl/rmf_pkg.sv
// Shared definitions of the running median filter: default sizes, register
// indexes and the control structs passed between the top level and the cells.
// No dependencies.
`timescale 1ns / 1ps

package rmf_pkg;

	localparam int MAX_WINDOW_DEF   = 32;
	localparam int SAMPLE_WIDTH_DEF = 16;

	// The window length register has a fixed width of six bits.
	localparam int WL_W     = 6;
	localparam int WL_MIN   = 3;
	localparam int WL_RESET = 5;

	// Register index port width; leaves room for indexes beyond the register list.
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FILL_VALUE    = CFG_IDX_W'(1);

	// Row-wide control, the same for every cell.
	typedef struct packed {
		logic upd;   // a request is accepted: apply the remove/insert step
		logic load;  // a configuration write: reload every cell with the fill value
	} rmf_row_ctrl_t;

	// Where a cell sits relative to the current window.
	typedef struct packed {
		logic active;  // cell index is below the window length
		logic last;    // cell holds the largest entry of the window
	} rmf_cell_pos_t;

endpackage

// File: rtl/rmf_history.sv
// Circular sample history of the running median filter: a memory with one
// write and one registered read port, plus per-entry valid bits.
// Depends on nothing beyond its parameters.
`timescale 1ns / 1ps

module rmf_history #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     clr,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata,
	output logic                     rvld
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [WIDTH-1:0] rdata_q;
	logic             rvld_q;

	// The read is taken together with a write, always at a different address.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
			rdata_q    <= mem[raddr];
		end
	end

	// An entry that was never written since the last refill reads as the fill value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rvld_q  <= 1'b0;
		end else if (clr) begin
			valid_q <= '0;
			rvld_q  <= 1'b0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
			rvld_q         <= valid_q[raddr];
		end
	end

	assign rdata = rdata_q;
	assign rvld  = rvld_q;

endmodule

// File: rtl/rmf_cell.sv
// One cell of the sorted row: holds one entry of the ascending window copy and
// works out its next value from its own entry and its two neighbors.
// Depends on rmf_pkg.
`timescale 1ns / 1ps

module rmf_cell #(
	parameter int SW = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rmf_pkg::rmf_row_ctrl_t ctrl,
	input  rmf_pkg::rmf_cell_pos_t pos,
	input  logic signed [SW-1:0]  fill,
	input  logic signed [SW-1:0]  vold,
	input  logic signed [SW-1:0]  vnew,
	input  logic signed [SW-1:0]  right_val,
	input  logic signed [SW-1:0]  left_r,
	input  logic                  left_lt,
	output logic signed [SW-1:0]  val,
	output logic signed [SW-1:0]  r,
	output logic                  r_lt
);

	import rmf_pkg::*;

	logic signed [SW-1:0] val_q;
	logic signed [SW-1:0] val_nxt;

	// Removal: entries below the old sample stay, the rest move down by one.
	// Insertion: entries below the new sample stay, the first one that is not
	// below takes the new sample, the rest take the left neighbor.
	always_comb begin
		r       = (val_q < vold) ? val_q : right_val;
		r_lt    = !pos.last && (r < vnew);
		val_nxt = r_lt ? r : (left_lt ? vnew : left_r);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
		end else if (ctrl.load) begin
			val_q <= fill;
		end else if (ctrl.upd && pos.active) begin
			val_q <= val_nxt;
		end
	end

	assign val = val_q;

endmodule

// File: rtl/running_median_filter_unit.sv
// Top level of the running median filter: configuration registers, write
// position, history memory, the row of sorted cells and the output stage.
// Depends on rmf_pkg, rmf_history and rmf_cell.
`timescale 1ns / 1ps

// Channel   Direction  Signals                      Request carries
// input     in         in_valid, in_stall, sample   one signed sample
// output    out        out_valid, out_stall, median one signed median
// config    in         cfg_we, cfg_idx, cfg_data    one register write
//
// One request is taken per cycle while the input does not stall. The request
// first updates the row of sorted cells; the output register then takes the
// middle entries. The input stalls only while a finished median waits in stage
// one and the output register cannot take it because the output side stalls.
// Reset and every configuration write to a known register refill the window
// with the fill value at once; no clearing pass is needed.
module running_median_filter_unit #(
	parameter int MAX_WINDOW   = rmf_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_WIDTH = rmf_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rmf_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [SAMPLE_WIDTH-1:0]        cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [SAMPLE_WIDTH-1:0] median
);

	import rmf_pkg::*;

	localparam int SW = SAMPLE_WIDTH;
	localparam int PW = $clog2(MAX_WINDOW);
	localparam int NW = $clog2(MAX_WINDOW + 1);
	localparam int RESET_N = (WL_RESET > MAX_WINDOW) ? MAX_WINDOW : WL_RESET;

	// Configuration state. The window length is kept already clamped, with
	// its middle index alongside.
	logic [NW-1:0]        n_q;
	logic [PW-1:0]        mid_q;
	logic signed [SW-1:0] fill_q;
	logic [NW-1:0]        n_cfg;
	logic signed [SW-1:0] fill_nxt;
	logic                 cfg_hit;

	// Write position and the addresses of this request and the next one.
	logic [PW-1:0] wp_q;
	logic [PW-1:0] wr_addr;
	logic [PW-1:0] rd_addr;

	// History read of the sample that the next request overwrites.
	logic [SW-1:0]        hist_rdata;
	logic                 hist_rvld;
	logic signed [SW-1:0] vold;

	// Cell row.
	rmf_row_ctrl_t        row_ctrl;
	logic signed [SW-1:0] cell_val [MAX_WINDOW];
	logic signed [SW-1:0] cell_r   [MAX_WINDOW];
	logic                 cell_lt  [MAX_WINDOW];

	// Pipeline and output stage.
	logic                 accept;
	logic                 out_free;
	logic                 item_vld_s1;
	logic                 out_valid_q;
	logic signed [SW-1:0] median_q;
	logic signed [SW-1:0] mid_hi;
	logic signed [SW-1:0] mid_lo;
	logic signed [SW:0]   mid_sum;
	logic signed [SW-1:0] med_calc;

	//------------------------------------------------------------------
	// Configuration
	//------------------------------------------------------------------
	assign cfg_hit = cfg_we && (cfg_idx == REG_WINDOW_LENGTH || cfg_idx == REG_FILL_VALUE);

	// Lengths below three act as three, lengths above the row act as the row.
	always_comb begin
		if (cfg_data[WL_W-1:0] < WL_W'(WL_MIN)) begin
			n_cfg = NW'(WL_MIN);
		end else if (32'(cfg_data[WL_W-1:0]) > 32'(MAX_WINDOW)) begin
			n_cfg = NW'(MAX_WINDOW);
		end else begin
			n_cfg = NW'(cfg_data[WL_W-1:0]);
		end
	end

	// The refill after a write uses the fill value as it stands after that write.
	assign fill_nxt = (cfg_we && cfg_idx == REG_FILL_VALUE) ? $signed(cfg_data) : fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q    <= NW'(RESET_N);
			mid_q  <= PW'(RESET_N / 2);
			fill_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_WINDOW_LENGTH: begin
					n_q   <= n_cfg;
					mid_q <= PW'(n_cfg >> 1);
				end
				REG_FILL_VALUE: fill_q <= fill_nxt;
				default: ;
			endcase
		end
	end

	//------------------------------------------------------------------
	// Write position: advances by one modulo the window length per request.
	//------------------------------------------------------------------
	assign accept = in_valid && !in_stall;

	assign wr_addr = (NW'(wp_q) + NW'(1) == n_q) ? '0 : wp_q + 1'b1;
	assign rd_addr = (NW'(wr_addr) + NW'(1) == n_q) ? '0 : wr_addr + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
		end else if (cfg_hit) begin
			wp_q <= '0;
		end else if (accept) begin
			wp_q <= wr_addr;
		end
	end

	//------------------------------------------------------------------
	// History. Each request writes its sample and fetches the sample that
	// the following request replaces, so the old value is ready in time.
	//------------------------------------------------------------------
	rmf_history #(
		.DEPTH(MAX_WINDOW),
		.WIDTH(SW)
	) u_history (
		.clk   (clk),
		.arst_n(arst_n),
		.clr   (cfg_hit),
		.we    (accept),
		.waddr (wr_addr),
		.wdata (sample),
		.raddr (rd_addr),
		.rdata (hist_rdata),
		.rvld  (hist_rvld)
	);

	assign vold = hist_rvld ? $signed(hist_rdata) : fill_q;

	//------------------------------------------------------------------
	// Sorted row. Each cell sees only its neighbors; cell zero sees an
	// imaginary left neighbor below every sample.
	//------------------------------------------------------------------
	assign row_ctrl.upd  = accept;
	assign row_ctrl.load = cfg_hit;

	for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
		rmf_cell_pos_t        pos;
		logic signed [SW-1:0] right_val;
		logic signed [SW-1:0] left_r;
		logic                 left_lt;

		assign pos.active = NW'(k) < n_q;
		assign pos.last   = NW'(k) == n_q - NW'(1);

		if (k == 0) begin : g_first
			assign left_r  = '0;
			assign left_lt = 1'b1;
		end else begin : g_inner
			assign left_r  = cell_r[k-1];
			assign left_lt = cell_lt[k-1];
		end

		if (k == MAX_WINDOW - 1) begin : g_end
			assign right_val = '0;
		end else begin : g_mid
			assign right_val = cell_val[k+1];
		end

		rmf_cell #(
			.SW(SW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (row_ctrl),
			.pos      (pos),
			.fill     (fill_nxt),
			.vold     (vold),
			.vnew     (sample),
			.right_val(right_val),
			.left_r   (left_r),
			.left_lt  (left_lt),
			.val      (cell_val[k]),
			.r        (cell_r[k]),
			.r_lt     (cell_lt[k])
		);
	end

	//------------------------------------------------------------------
	// Median pick and output register. Stage one marks that the row holds
	// the window of a request whose median is still to be taken.
	//------------------------------------------------------------------
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = item_vld_s1 && !out_free;

	assign mid_hi   = cell_val[mid_q];
	assign mid_lo   = cell_val[mid_q - 1'b1];
	assign mid_sum  = {mid_hi[SW-1], mid_hi} + {mid_lo[SW-1], mid_lo};
	assign med_calc = n_q[0] ? mid_hi : mid_sum[SW:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_vld_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			item_vld_s1 <= accept || (item_vld_s1 && !out_free);
			if (out_free) begin
				out_valid_q <= item_vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && item_vld_s1) begin
			median_q <= med_calc;
		end
	end

	assign out_valid = out_valid_q;
	assign median    = median_q;

	//------------------------------------------------------------------
	// Assertions
	//------------------------------------------------------------------
	logic row_sorted;

	always_comb begin
		row_sorted = 1'b1;
		for (int k = 0; k < MAX_WINDOW - 1; k++) begin
			if (NW'(k + 1) < n_q && cell_val[k] > cell_val[k+1]) begin
				row_sorted = 1'b0;
			end
		end
	end

	a_row_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		row_sorted)
		else $error("sorted row lost its ascending order");

	a_pos_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		NW'(wp_q) < n_q)
		else $error("write position outside the window");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		n_q >= NW'(WL_MIN) && 32'(n_q) <= 32'(MAX_WINDOW) && mid_q == PW'(n_q >> 1))
		else $error("window length or middle index out of range");

	a_accept_pending: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> item_vld_s1)
		else $error("accepted request lost before the median pick");

	a_refill_pos: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_hit |=> wp_q == '0 && !hist_rvld)
		else $error("refill did not clear position and history read");

endmodule

// File: test/tb_running_median_filter_unit.sv
// Self-checking testbench for running_median_filter_unit. It streams signed samples
// through the filter and compares every median with a predictor that runs in the bench.
// Depends on rmf_pkg and the RTL of the filter.
`timescale 1ns / 1ps

module tb_running_median_filter_unit;
	import rmf_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int WIN_MAX      = MAX_WINDOW_DEF;
	localparam int SW           = SAMPLE_WIDTH_DEF;
	localparam int POS_W        = $clog2(WIN_MAX);
	localparam int PIPE_DEPTH   = 2;     // registers between request and median in the top level
	localparam int STUCK_LIMIT  = 2000;  // cycles without any request moving
	localparam int REPORT_LIMIT = 10;
	localparam int RAND_PHASES  = 12;

	// Indexes that the port can carry but that name no register.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

	typedef logic signed [SW-1:0] sample_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx   = '0;
	logic [SW-1:0]        cfg_data  = '0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	sample_t              sample    = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	sample_t              median;

	running_median_filter_unit #(
		.MAX_WINDOW  (WIN_MAX),
		.SAMPLE_WIDTH(SW)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sample   (sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.median   (median)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Predictor state: register copies, the circular history and its sorted twin.
	logic [WL_W-1:0]  model_wlen;
	sample_t          model_fill;
	sample_t          win_hist[WIN_MAX];
	sample_t          win_sorted[WIN_MAX];
	logic [POS_W-1:0] win_pos;

	sample_t pending_samples[$];   // samples waiting for the driver
	sample_t expected_medians[$];  // medians owed by the block, oldest first
	sample_t median_want;

	logic in_fire     = 1'b0;
	logic steady_feed = 1'b0;
	int   burst_left  = 0;
	int   gap_left    = 0;
	int   stuck_cycles  = 0;
	int   fail_count    = 0;
	int   samples_taken = 0;
	int   medians_seen  = 0;
	int   reg_writes    = 0;

	logic [31:0] stall_bits = '0;
	logic [4:0]  stall_phase = '0;

	function automatic void reload_window();
		foreach (win_hist[k]) begin
			win_hist[k]   = model_fill;
			win_sorted[k] = model_fill;
		end
		win_pos = '0;
	endfunction

	function automatic void write_filter_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [SW-1:0] data);
		case (idx)
			REG_WINDOW_LENGTH: begin
				model_wlen = data[WL_W-1:0];
				reload_window();
			end
			REG_FILL_VALUE: begin
				model_fill = data;
				reload_window();
			end
			default: ;  // an index past the register list leaves the window alone
		endcase
	endfunction

	// Advances the window by one sample and returns the new median.
	function automatic sample_t median_after_sample(input sample_t x);
		int      n;
		int      slot;
		int      k;
		sample_t evicted;
		logic [SW:0] pair_sum;
		n = int'(model_wlen);
		if (n < WL_MIN) n = WL_MIN;
		if (n > WIN_MAX) n = WIN_MAX;
		slot = (int'(win_pos) + 1) % n;
		win_pos = POS_W'(slot);
		evicted = win_hist[slot];
		win_hist[slot] = x;
		// Remove the first sorted entry equal to the sample that leaves the window.
		k = 0;
		while (k < n - 1 && win_sorted[k] != evicted) k++;
		while (k < n - 1) begin
			win_sorted[k] = win_sorted[k + 1];
			k++;
		end
		// Insert in front of the first entry that is not smaller.
		slot = 0;
		while (slot < n - 1 && win_sorted[slot] < x) slot++;
		for (k = n - 1; k > slot; k--) win_sorted[k] = win_sorted[k - 1];
		win_sorted[slot] = x;
		if (n % 2 == 1) return win_sorted[n / 2];
		// Even window: 17-bit sum of the middle pair, floored by dropping its low bit.
		pair_sum = {win_sorted[n / 2][SW-1], win_sorted[n / 2]}
			+ {win_sorted[n / 2 - 1][SW-1], win_sorted[n / 2 - 1]};
		return pair_sum[SW:1];
	endfunction

	// Prediction, result checking and the watchdog, all on the rising edge.
	always @(posedge clk) begin
		in_fire <= arst_n && in_valid && !in_stall;
		if (arst_n) begin
			if (cfg_we) begin
				write_filter_register(cfg_idx, cfg_data);
				reg_writes++;
			end
			if (in_valid && !in_stall) begin
				expected_medians.push_back(median_after_sample(sample));
				samples_taken++;
			end
			if (out_valid && !out_stall) begin
				medians_seen++;
				if (expected_medians.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display("Unexpected median %0d at %0t", median, $time);
				end else begin
					median_want = expected_medians.pop_front();
					if (median !== median_want) begin
						fail_count++;
						if (fail_count <= REPORT_LIMIT)
							$display("Median mismatch at %0t: got %0d, expected %0d",
								$time, median, median_want);
					end
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
				stuck_cycles = 0;
			end else begin
				stuck_cycles++;
				if (stuck_cycles >= STUCK_LIMIT) begin
					$display("Timeout: no request moved for %0d cycles", STUCK_LIMIT);
					$display("TEST FAILED");
					$finish;
				end
			end
		end
	end

	// Sender: bursts of requests with random gaps; a request is held until taken.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_fire) begin
			if (gap_left != 0 || pending_samples.size() == 0) begin
				in_valid <= 1'b0;
				if (gap_left != 0) gap_left--;
			end else begin
				in_valid <= 1'b1;
				sample   <= pending_samples.pop_front();
				if (burst_left == 0) burst_left = $urandom_range(1, 24);
				burst_left--;
				if (burst_left == 0)
					gap_left = (steady_feed || $urandom_range(0, 3) == 0) ? 0
						: $urandom_range(1, 5);
			end
		end
	end

	// Receiver: stalls follow a random pattern in stall_bits that is redrawn each time its phase wraps.
	always @(negedge clk) begin
		if (stall_phase == 0) begin
			case ($urandom_range(0, 3))
				0: stall_bits = '0;
				1: stall_bits = $urandom & $urandom;
				2: stall_bits = $urandom;
				default: stall_bits = $urandom | $urandom;
			endcase
		end
		out_stall <= stall_bits[stall_phase];
		stall_phase = stall_phase + 1'b1;
	end

	// Waits until no sample is queued or in flight, then lets the pipeline settle.
	task automatic wait_for_drain();
		do @(posedge clk);
		while (pending_samples.size() != 0 || in_valid || expected_medians.size() != 0);
		repeat (PIPE_DEPTH + 1) @(negedge clk);
	endtask

	// Called at a falling edge while the filter is idle.
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [SW-1:0] data);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		sample_t opening[]  = '{16'sh7FFF, 16'sh8000, 16'sh0000, -16'sd1, 16'sd1,
			16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh5555, 16'shAAAA};
		sample_t carry_on[] = '{16'sh8000, 16'sh8000, 16'sd7};
		sample_t even_win[] = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
			-16'sd1, 16'sd0, -16'sd1, 16'sd0, 16'sh8000};
		sample_t after_reload[] = '{16'sd100, -16'sd100};
		int          window_plan[6] = '{WL_MIN, WIN_MAX, 0, 63, 2, WIN_MAX + 1};
		int          ph;
		int          count;
		int          mode;
		int          wl_pick;
		logic [SW-1:0] wl_data;
		sample_t     fill_pick;
		sample_t     level;

		model_wlen = WL_RESET;
		model_fill = '0;
		reload_window();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: odd window of five over a zero fill, with both sample extremes.
		foreach (opening[i]) pending_samples.push_back(opening[i]);
		wait_for_drain();

		// Writes past the register list must not disturb the running window.
		write_register(REG_SPARE_2, 16'hFFFF);
		write_register(REG_SPARE_3, 16'h0000);
		foreach (carry_on[i]) pending_samples.push_back(carry_on[i]);
		wait_for_drain();

		// Even window over the most negative fill: the pair sum needs its seventeenth bit,
		// and a middle pair of -1 and 0 must floor to -1.
		write_register(REG_FILL_VALUE, 16'h8000);
		write_register(REG_WINDOW_LENGTH, 16'd4);
		foreach (even_win[i]) pending_samples.push_back(even_win[i]);
		wait_for_drain();

		// Rewriting the same length still reloads the window with the fill value.
		write_register(REG_WINDOW_LENGTH, 16'd4);
		foreach (after_reload[i]) pending_samples.push_back(after_reload[i]);

		for (ph = 0; ph < RAND_PHASES; ph++) begin
			wait_for_drain();
			wl_pick = (ph < 6) ? window_plan[ph] : $urandom_range(0, 63);
			wl_data = {10'($urandom_range(0, 1023)), 6'(wl_pick)};
			case ($urandom_range(0, 3))
				0: fill_pick = 16'sh8000;
				1: fill_pick = 16'sh7FFF;
				default: fill_pick = sample_t'($urandom);
			endcase
			if ($urandom_range(0, 3) == 0)
				write_register($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
					16'($urandom));
			// Every third phase keeps the old fill, so only the length write reloads.
			if (ph % 3 != 2) write_register(REG_FILL_VALUE, fill_pick);
			write_register(REG_WINDOW_LENGTH, wl_data);

			mode = ph % 4;
			steady_feed = (ph % 5 == 4);
			count = $urandom_range(45, 65);
			level = model_fill;
			repeat (count) begin
				case (mode)
					0: level = sample_t'($urandom);
					// Close to the fill value, so ties with old entries are frequent.
					1: level = model_fill + sample_t'($urandom_range(0, 6)) - 16'sd3;
					2: begin
						case ($urandom_range(0, 4))
							0: level = 16'sh8000;
							1: level = 16'sh7FFF;
							2: level = -16'sd1;
							3: level = 16'sd0;
							default: level = model_fill;
						endcase
					end
					default: level = level + sample_t'($urandom_range(0, 600)) - 16'sd300;
				endcase
				pending_samples.push_back(level);
			end
		end

		wait_for_drain();
		$display("Run covered %0d samples and %0d medians over %0d register writes,",
			samples_taken, medians_seen, reg_writes);
		$display("windows from below the minimum to above the maximum, odd and even.");
		if (fail_count == 0 && expected_medians.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d failures, %0d medians never delivered", fail_count,
				expected_medians.size());
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
